// ----- rtl/core/sfr_pkg.sv -----
// Shared types and constants of the serial frame receiver.
// Holds the opcodes, byte codes, frame lengths, the state enums and the
// command/status structs between the controller and the datapath.
package sfr_pkg;

  localparam int unsigned BufDepthDef = 16;

  localparam logic [1:0] OpByte    = 2'd0;
  localparam logic [1:0] OpRestart = 2'd1;
  localparam logic [1:0] OpTick    = 2'd2;

  localparam logic [7:0] ByteEsc   = 8'h55;
  localparam logic [7:0] ByteHdr   = 8'hFE;
  localparam logic [7:0] ByteCmd1  = 8'h01;
  localparam logic [7:0] ByteCmd2  = 8'h02;
  localparam logic [7:0] ByteCmd3  = 8'h03;
  localparam logic [7:0] ByteCmd4  = 8'h04;
  localparam logic [7:0] ByteSub5  = 8'h05;
  localparam logic [7:0] ByteSub6  = 8'h06;

  localparam logic [4:0] LenCmd1   = 5'd9;
  localparam logic [4:0] LenEight  = 5'd8;
  localparam logic [4:0] LenSeven  = 5'd7;
  localparam logic [4:0] LenLong   = 5'd16;
  localparam logic [4:0] HdrLen    = 5'd3;

  localparam logic [15:0] TimeoutDef = 16'd500;

  typedef enum logic [3:0] {
    PS_IDLE,
    PS_FIND,
    PS_PAYLOAD,
    PS_C1,
    PS_C2,
    PS_C3,
    PS_C3_LONG,
    PS_C3_SHORT,
    PS_C4,
    PS_C4_LONG,
    PS_C4_SHORT,
    PS_READY
  } parse_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_WRITE,
    CS_DUMP_RD,
    CS_DUMP_WAIT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic wr_step;
    logic rd_en;
    logic load_byte;
    logic load_tmo;
  } sfr_cmd_t;

  typedef struct packed {
    logic [1:0] pend_n;
    logic       emit;
    logic       last_byte;
    logic       out_free;
    logic       tmo_pend;
  } sfr_sts_t;

endpackage

// ----- rtl/core/sfr_in_if.sv -----
// Input channel of the serial frame receiver: valid/ready plus one item.
// Depends on nothing.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

// ----- rtl/core/sfr_out_if.sv -----
// Result channel of the serial frame receiver: valid/ready plus one result.
// Depends on nothing.
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [3:0] byte_index;
  logic [4:0] frame_length;
  logic       last;
  logic       timed_out;

  modport source (output valid, output frame_byte, output byte_index,
                  output frame_length, output last, output timed_out, input ready);
  modport sink (input valid, input frame_byte, input byte_index,
                input frame_length, input last, input timed_out, output ready);
endinterface

// ----- rtl/core/sfr_ctrl.sv -----
// Sequencer of the serial frame receiver: input handshake, buffered writes,
// frame dump and timeout delivery. Depends on sfr_pkg.
module sfr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sfr_pkg::sfr_sts_t sts_i,
  output sfr_pkg::sfr_cmd_t cmd_o
);
  import sfr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      CS_IDLE: begin
        // A reported timeout leaves before any further item is taken.
        if (sts_i.tmo_pend) begin
          cmd_o.load_tmo = sts_i.out_free;
        end else begin
          in_ready_o   = 1'b1;
          cmd_o.accept = in_valid_i;
          if (in_valid_i) begin
            state_d = CS_WRITE;
          end
        end
      end
      CS_WRITE: begin
        cmd_o.wr_step = (sts_i.pend_n != 2'd0);
        if (sts_i.pend_n <= 2'd1) begin
          state_d = sts_i.emit ? CS_DUMP_RD : CS_IDLE;
        end
      end
      CS_DUMP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = CS_DUMP_WAIT;
      end
      CS_DUMP_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_byte = 1'b1;
          state_d         = sts_i.last_byte ? CS_IDLE : CS_DUMP_RD;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/sfr_dpath.sv -----
// Datapath of the serial frame receiver: frame parser registers, frame
// store, timeout counter and result register. Depends on sfr_pkg.
module sfr_dpath #(
  parameter int unsigned BUF_DEPTH = sfr_pkg::BufDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfr_pkg::sfr_cmd_t cmd_i,
  output sfr_pkg::sfr_sts_t sts_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        frame_byte_o,
  output logic [3:0]        byte_index_o,
  output logic [4:0]        frame_length_o,
  output logic              last_o,
  output logic              timed_out_o
);
  import sfr_pkg::*;

  localparam int unsigned WPW = $clog2(BUF_DEPTH + 1);
  localparam int unsigned AW  = $clog2(BUF_DEPTH);
  localparam logic [WPW-1:0] WpMax = WPW'(BUF_DEPTH);

  parse_state_e   ps_q, ps_d;
  logic           esc_q, esc_d;
  logic [1:0]     fec_q, fec_d;
  logic [WPW-1:0] wp_q, wp_d;
  logic [WPW-1:0] wr_ptr_q, base_d;
  logic [1:0]     pend_n_q, pend_n_d;
  logic [7:0]     pend_b_q, pend_b_d;
  logic [4:0]     emit_len_q, emit_len_d;
  logic [3:0]     dump_idx_q;
  logic [7:0]     rdata_q;
  logic [7:0]     mem [BUF_DEPTH];

  logic [15:0]    ticks_q;
  logic [15:0]    tmo_cnt_q, tmo_cnt_d;
  logic           tmo_rep_q, tmo_rep_d;
  logic           tmo_pend_q, tmo_set;

  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic [3:0]     out_idx_q;
  logic [4:0]     out_len_q;
  logic           out_last_q;
  logic           out_tmo_q;

  logic           is_byte;
  logic           last_byte;
  logic           out_free;

  assign is_byte   = (opcode_i == OpByte);
  assign last_byte = (({1'b0, dump_idx_q} + 5'd1) == emit_len_q);
  assign out_free  = !out_valid_q || out_ready_i;

  // Parse step for one accepted item; writes to the store are queued.
  always_comb begin : decode
    logic [WPW-1:0] wp_inc;
    logic [1:0]     fec_inc;
    logic           counted;
    logic [4:0]     tgt;
    wp_inc     = (wp_q < WpMax) ? wp_q + 1'b1 : wp_q;
    fec_inc    = fec_q + 2'd1;
    counted    = 1'b0;
    tgt        = LenEight;
    ps_d       = ps_q;
    esc_d      = esc_q;
    fec_d      = fec_q;
    wp_d       = wp_q;
    base_d     = wp_q;
    pend_n_d   = 2'd0;
    pend_b_d   = rx_byte_i;
    emit_len_d = 5'd0;
    if (opcode_i == OpRestart) begin
      wp_d  = '0;
      esc_d = 1'b0;
      ps_d  = PS_FIND;
    end else if (is_byte) begin
      case (ps_q)
        PS_IDLE, PS_FIND: begin
          if (rx_byte_i == ByteEsc) begin
            esc_d = 1'b1;
          end else if (rx_byte_i == ByteHdr) begin
            fec_d = fec_inc;
            if (fec_inc == 2'd2) begin
              if (esc_q) begin
                base_d   = '0;
                pend_n_d = 2'd3;
                pend_b_d = ByteEsc;
                wp_d     = WPW'(HdrLen);
                esc_d    = 1'b0;
              end
              ps_d  = PS_PAYLOAD;
              fec_d = 2'd0;
            end
          end else begin
            esc_d = 1'b0;
          end
        end
        PS_PAYLOAD: begin
          if (rx_byte_i == ByteEsc) begin
            esc_d = !esc_q;
            if (esc_q) begin
              pend_n_d = 2'd1;
              pend_b_d = ByteEsc;
              wp_d     = wp_inc;
            end
          end else begin
            if (esc_q) begin
              pend_n_d = 2'd1;
              pend_b_d = ByteEsc;
              wp_d     = wp_inc;
              // An escaped header byte restarts the payload after the header.
              if (rx_byte_i == ByteHdr) begin
                pend_n_d = 2'd3;
                wp_d     = WPW'(HdrLen);
              end
            end else if (rx_byte_i >= ByteCmd1 && rx_byte_i <= ByteCmd4) begin
              pend_n_d = 2'd1;
              wp_d     = wp_inc;
              case (rx_byte_i)
                ByteCmd1: ps_d = PS_C1;
                ByteCmd2: ps_d = PS_C2;
                ByteCmd3: ps_d = PS_C3;
                default:  ps_d = PS_C4;
              endcase
            end
            esc_d = 1'b0;
          end
        end
        PS_C1: begin
          counted = 1'b1;
          tgt     = LenCmd1;
        end
        PS_C2, PS_C3_LONG, PS_C4_SHORT: begin
          counted = 1'b1;
          tgt     = LenEight;
        end
        PS_C3_SHORT: begin
          counted = 1'b1;
          tgt     = LenSeven;
        end
        PS_C4_LONG: begin
          counted = 1'b1;
          tgt     = LenLong;
        end
        PS_C3: begin
          pend_n_d = 2'd1;
          wp_d     = wp_inc;
          ps_d     = (rx_byte_i == ByteCmd4 || rx_byte_i == ByteSub5 ||
                      rx_byte_i == ByteSub6) ? PS_C3_LONG : PS_C3_SHORT;
        end
        PS_C4: begin
          pend_n_d = 2'd1;
          wp_d     = wp_inc;
          ps_d     = (rx_byte_i == ByteCmd2) ? PS_C4_LONG : PS_C4_SHORT;
        end
        default: begin
          ps_d = ps_q;
        end
      endcase
      if (counted) begin
        pend_n_d = 2'd1;
        wp_d     = wp_inc;
        if (wp_inc == WPW'(tgt)) begin
          ps_d       = PS_READY;
          emit_len_d = tgt;
        end
      end
    end
  end

  always_comb begin : timer
    logic [15:0] dec;
    dec       = (tmo_cnt_q != 16'd0) ? tmo_cnt_q - 16'd1 : tmo_cnt_q;
    tmo_cnt_d = tmo_cnt_q;
    tmo_rep_d = tmo_rep_q;
    tmo_set   = 1'b0;
    if (is_byte || opcode_i == OpRestart) begin
      tmo_cnt_d = ticks_q;
      tmo_rep_d = 1'b0;
    end else if (opcode_i == OpTick) begin
      tmo_cnt_d = dec;
      if (dec == 16'd0 && !tmo_rep_q) begin
        tmo_rep_d = 1'b1;
        tmo_set   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q        <= PS_IDLE;
      esc_q       <= 1'b0;
      fec_q       <= 2'd0;
      wp_q        <= '0;
      wr_ptr_q    <= '0;
      pend_n_q    <= 2'd0;
      emit_len_q  <= 5'd0;
      dump_idx_q  <= 4'd0;
      ticks_q     <= TimeoutDef;
      tmo_cnt_q   <= TimeoutDef;
      tmo_rep_q   <= 1'b0;
      tmo_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        ps_q       <= ps_d;
        esc_q      <= esc_d;
        fec_q      <= fec_d;
        wp_q       <= wp_d;
        wr_ptr_q   <= base_d;
        pend_n_q   <= pend_n_d;
        emit_len_q <= emit_len_d;
        dump_idx_q <= 4'd0;
        tmo_cnt_q  <= tmo_cnt_d;
        tmo_rep_q  <= tmo_rep_d;
        tmo_pend_q <= tmo_set;
      end else if (cmd_i.load_tmo) begin
        tmo_pend_q <= 1'b0;
      end
      if (cmd_i.wr_step) begin
        pend_n_q <= pend_n_q - 2'd1;
        if (wr_ptr_q < WpMax) begin
          wr_ptr_q <= wr_ptr_q + 1'b1;
        end
      end
      if (cmd_i.load_byte) begin
        dump_idx_q <= dump_idx_q + 4'd1;
      end
      if (cmd_i.load_byte || cmd_i.load_tmo) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pend_b_q <= pend_b_d;
    end else if (cmd_i.wr_step) begin
      pend_b_q <= ByteHdr;
    end
    if (cmd_i.load_byte) begin
      out_byte_q <= rdata_q;
      out_idx_q  <= dump_idx_q;
      out_len_q  <= emit_len_q;
      out_last_q <= last_byte;
      out_tmo_q  <= 1'b0;
    end else if (cmd_i.load_tmo) begin
      out_byte_q <= 8'd0;
      out_idx_q  <= 4'd0;
      out_len_q  <= 5'd0;
      out_last_q <= 1'b0;
      out_tmo_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_step && (wr_ptr_q < WpMax)) begin
      mem[wr_ptr_q[AW-1:0]] <= pend_b_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[AW'(dump_idx_q)];
    end
  end

  assign sts_o.pend_n    = pend_n_q;
  assign sts_o.emit      = (emit_len_q != 5'd0);
  assign sts_o.last_byte = last_byte;
  assign sts_o.out_free  = out_free;
  assign sts_o.tmo_pend  = tmo_pend_q;

  assign out_valid_o    = out_valid_q;
  assign frame_byte_o   = out_byte_q;
  assign byte_index_o   = out_idx_q;
  assign frame_length_o = out_len_q;
  assign last_o         = out_last_q;
  assign timed_out_o    = out_tmo_q;

endmodule

// ----- rtl/core/serial_frame_receiver_core.sv -----
// Top level of the serial frame receiver: controller plus datapath.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_ctrl and sfr_dpath.
//
//   channel   direction  handshake      contents
//   in_ch     in         valid/ready    opcode, rx_byte
//   out_ch    out        valid/ready    frame_byte, byte_index, frame_length,
//                                       last, timed_out
//   cfg       in         cfg_we_i       cfg_wdata_i = timeout_ticks
//
// An item is accepted, then its stored bytes (at most three) are written one by one
// through the single write port of the frame store; no new item is taken meanwhile.
// A completed frame is then dumped byte by byte (store read, then result register);
// each load of the result register waits until out_ch is free.
// Reset clears all control state; the frame store holds no reset value.
// A stalled out_ch holds one result; input is taken meanwhile unless a dump
// or a pending timeout result needs the result register.
module serial_frame_receiver_core #(
  parameter int unsigned BUF_DEPTH = sfr_pkg::BufDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  sfr_in_if.sink      in_ch,
  sfr_out_if.source   out_ch
);
  import sfr_pkg::*;

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfr_dpath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (in_ch.opcode),
    .rx_byte_i      (in_ch.rx_byte),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .frame_byte_o   (out_ch.frame_byte),
    .byte_index_o   (out_ch.byte_index),
    .frame_length_o (out_ch.frame_length),
    .last_o         (out_ch.last),
    .timed_out_o    (out_ch.timed_out)
  );

endmodule

// ----- bench/serial_frame_receiver_checker.sv -----
// Checker for the serial frame receiver: predicts the frame and timeout results
// from the accepted input transfers and compares them with the result channel.
// Depends on sfr_pkg, sfr_in_if and sfr_out_if.
module serial_frame_receiver_checker #(
  parameter int unsigned BUF_DEPTH = sfr_pkg::BufDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  sfr_in_if           in_ch,
  sfr_out_if          out_ch,
  output int unsigned fail_count_o,
  output int unsigned results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int PosW = $clog2(BUF_DEPTH) + 1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [3:0] byte_index;
    logic [4:0] frame_length;
    logic       last;
    logic       timed_out;
  } frame_result_t;

  frame_result_t results_due[$];
  int unsigned   miss_count;

  logic [15:0]     timeout_ticks;
  parse_state_e    parse_state;
  logic            saw_escape;
  logic [1:0]      hdr_fe_seen;
  logic [PosW-1:0] wr_pos;
  logic [7:0]      frame_mem [BUF_DEPTH];
  logic [15:0]     tmo_left;
  logic            tmo_flagged;

  function automatic void note_miss(string what);
    miss_count++;
    if (miss_count <= 10) begin
      $display("%0t ns: %s", $realtime, what);
    end
  endfunction

  // Writes past the end of the store are dropped and the position stays put.
  function automatic void store_byte(logic [7:0] b);
    if (wr_pos < BUF_DEPTH) begin
      frame_mem[wr_pos] = b;
      wr_pos++;
    end
  endfunction

  function automatic logic [4:0] store_toward(logic [7:0] b, logic [4:0] target);
    store_byte(b);
    if (wr_pos == target) begin
      parse_state = PS_READY;
    end
    return (parse_state == PS_READY) ? target : 5'd0;
  endfunction

  // Returns the frame length when this byte completes a frame, else zero.
  function automatic logic [4:0] decode_byte(logic [7:0] b);
    logic [4:0] done_len;
    done_len = '0;
    case (parse_state)
      PS_IDLE, PS_FIND: begin
        if (b == ByteEsc) begin
          saw_escape = 1'b1;
        end else if (b == ByteHdr) begin
          hdr_fe_seen = hdr_fe_seen + 2'd1;
          if (hdr_fe_seen == 2'd2) begin
            // The header is only stored when the escape byte came first.
            if (saw_escape) begin
              wr_pos = '0;
              store_byte(ByteEsc);
              store_byte(ByteHdr);
              store_byte(ByteHdr);
              saw_escape = 1'b0;
            end
            parse_state = PS_PAYLOAD;
            hdr_fe_seen = '0;
          end
        end else begin
          saw_escape = 1'b0;
        end
      end
      PS_PAYLOAD: begin
        if (b == ByteEsc) begin
          if (!saw_escape) begin
            saw_escape = 1'b1;
          end else begin
            saw_escape = 1'b0;
            store_byte(ByteEsc);
          end
        end else begin
          if (saw_escape) begin
            store_byte(ByteEsc);
            if (b == ByteHdr) begin
              store_byte(b);
              store_byte(b);
              wr_pos = HdrLen;
            end
          end else if (b >= ByteCmd1 && b <= ByteCmd4) begin
            store_byte(b);
            case (b)
              ByteCmd1: parse_state = PS_C1;
              ByteCmd2: parse_state = PS_C2;
              ByteCmd3: parse_state = PS_C3;
              default:  parse_state = PS_C4;
            endcase
          end
          saw_escape = 1'b0;
        end
      end
      PS_C1:       done_len = store_toward(b, LenCmd1);
      PS_C2:       done_len = store_toward(b, LenEight);
      PS_C3: begin
        store_byte(b);
        parse_state = (b == ByteCmd4 || b == ByteSub5 || b == ByteSub6) ?
                      PS_C3_LONG : PS_C3_SHORT;
      end
      PS_C3_LONG:  done_len = store_toward(b, LenEight);
      PS_C3_SHORT: done_len = store_toward(b, LenSeven);
      PS_C4: begin
        store_byte(b);
        parse_state = (b == ByteCmd2) ? PS_C4_LONG : PS_C4_SHORT;
      end
      PS_C4_LONG:  done_len = store_toward(b, LenLong);
      PS_C4_SHORT: done_len = store_toward(b, LenEight);
      default: ;
    endcase
    return done_len;
  endfunction

  function automatic void decode_item(logic [1:0] op, logic [7:0] b);
    logic [4:0]    flen;
    frame_result_t r;
    case (op)
      OpByte: begin
        flen = decode_byte(b);
        tmo_left = timeout_ticks;
        tmo_flagged = 1'b0;
        for (int i = 0; i < flen; i++) begin
          r.frame_byte = frame_mem[i];
          r.byte_index = 4'(i);
          r.frame_length = flen;
          r.last = (i + 1 == flen);
          r.timed_out = 1'b0;
          results_due.push_back(r);
        end
      end
      OpRestart: begin
        wr_pos = '0;
        saw_escape = 1'b0;
        parse_state = PS_FIND;
        tmo_left = timeout_ticks;
        tmo_flagged = 1'b0;
      end
      OpTick: begin
        if (tmo_left != 0) begin
          tmo_left--;
        end
        if (tmo_left == 0 && !tmo_flagged) begin
          tmo_flagged = 1'b1;
          r = '0;
          r.timed_out = 1'b1;
          results_due.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_ni) begin
      timeout_ticks = TimeoutDef;
      parse_state = PS_IDLE;
      saw_escape = 1'b0;
      hdr_fe_seen = '0;
      wr_pos = '0;
      frame_mem = '{default: '0};
      tmo_left = TimeoutDef;
      tmo_flagged = 1'b0;
      results_due.delete();
      miss_count = 0;
    end else begin
      if (cfg_we_i) begin
        timeout_ticks = cfg_wdata_i;
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_item(in_ch.opcode, in_ch.rx_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{frame_byte: out_ch.frame_byte, byte_index: out_ch.byte_index,
                frame_length: out_ch.frame_length, last: out_ch.last,
                timed_out: out_ch.timed_out};
        if (results_due.size() == 0) begin
          note_miss($sformatf("unexpected result byte %h idx %0d len %0d last %b tmo %b",
                              got.frame_byte, got.byte_index, got.frame_length,
                              got.last, got.timed_out));
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            note_miss($sformatf({"expected byte %h idx %0d len %0d last %b tmo %b, ",
                                 "got byte %h idx %0d len %0d last %b tmo %b"},
                                want.frame_byte, want.byte_index, want.frame_length,
                                want.last, want.timed_out, got.frame_byte,
                                got.byte_index, got.frame_length, got.last,
                                got.timed_out));
          end
        end
      end
    end
    fail_count_o <= miss_count;
    results_due_o <= results_due.size();
  end

endmodule

// ----- bench/serial_frame_receiver_core_test.sv -----
// Top of the serial frame receiver bench: clock, reset, stimulus and verdict.
// Depends on sfr_pkg, the two channel interfaces, serial_frame_receiver_core
// and serial_frame_receiver_checker.
module serial_frame_receiver_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned QuietLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned sent_count;
  int unsigned quiet_cycles;
  int unsigned fail_count;
  int unsigned results_due;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  serial_frame_receiver_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  serial_frame_receiver_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .results_due_o(results_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Any transfer on either channel proves the block is still alive.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("serial_frame_receiver_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid is only lowered when a gap is taken, so back-to-back items keep it high.
  task automatic send_item(input logic [1:0] op, input logic [7:0] b);
    if ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  // Holds the input until every predicted result has been taken, then lets
  // the last item finish inside the block.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    cfg_we <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OpByte, b);
  endtask

  task automatic send_frame();
    logic [7:0] cmd;
    logic [7:0] sub;
    int         body;
    if ($urandom_range(3) != 0) begin
      send_item(OpRestart, 8'($urandom));
    end
    repeat ($urandom_range(2)) send_byte(8'($urandom));
    send_byte(ByteEsc);
    send_byte(ByteHdr);
    send_byte(ByteHdr);
    if ($urandom_range(4) == 0) begin
      send_byte(ByteEsc);
      send_byte(ByteEsc);
    end
    if ($urandom_range(5) == 0) begin
      send_byte(ByteEsc);
      send_byte(ByteHdr);
    end
    if ($urandom_range(7) == 0) begin
      send_byte(8'($urandom));
    end
    cmd = 8'($urandom_range(ByteCmd4, ByteCmd1));
    send_byte(cmd);
    // The header and the command take the first four positions.
    case (cmd)
      ByteCmd1: body = int'(LenCmd1) - 4;
      ByteCmd2: body = int'(LenEight) - 4;
      ByteCmd3: begin
        sub = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(ByteSub6, ByteCmd4));
        body = ((sub == ByteCmd4 || sub == ByteSub5 || sub == ByteSub6) ?
                int'(LenEight) : int'(LenSeven)) - 4;
      end
      default: begin
        sub = ($urandom_range(1) == 0) ? ByteCmd2 : 8'($urandom);
        body = ((sub == ByteCmd2) ? int'(LenLong) : int'(LenEight)) - 4;
      end
    endcase
    repeat (body + $urandom_range(1)) begin
      if ($urandom_range(9) == 0) begin
        send_item(OpTick, 8'($urandom));
      end
      send_byte((cmd == ByteCmd3 || cmd == ByteCmd4) ? sub : 8'($urandom));
      sub = 8'($urandom);
    end
    repeat ($urandom_range(3)) send_item(OpTick, 8'($urandom));
  endtask

  task automatic run_segment(input logic [15:0] ticks, input int unsigned gap_pct,
                             input int unsigned stall_pct, input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    settle();
    write_timeout(ticks);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    start = sent_count;
    while (sent_count - start < n_items) begin
      pick = $urandom_range(19);
      if (pick < 13) begin
        send_frame();
      end else if (pick < 15) begin
        repeat ($urandom_range(8, 1)) send_item(OpTick, 8'($urandom));
      end else if (pick < 17) begin
        repeat ($urandom_range(6, 1)) send_item(2'($urandom), 8'($urandom));
      end else if (pick == 17) begin
        // More escaped pairs than a Cmd1 frame holds, so the frame overshoots its length.
        send_item(OpRestart, 8'($urandom));
        send_byte(ByteEsc);
        send_byte(ByteHdr);
        send_byte(ByteHdr);
        repeat (BufDepthDef / 2 + 1) begin
          send_byte(ByteEsc);
          send_byte(ByteEsc);
        end
        send_byte(ByteCmd1);
        repeat (3) send_byte(8'($urandom));
      end else begin
        settle();
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OpByte;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sent_count = 0;
    send_gap_pct = 25;
    recv_stall_pct = 64;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_timeout(16'd2);

    send_item(OpUnused, 8'hA5);
    send_item(OpTick, 8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ByteEsc);
    send_byte(ByteHdr);
    send_byte(ByteHdr);
    // Unknown command, then an escape followed by an ordinary byte.
    send_byte(8'h09);
    send_byte(ByteEsc);
    send_byte(8'h33);
    // Escape and header byte inside the payload rewind it to position three.
    send_byte(ByteEsc);
    send_byte(ByteHdr);
    send_byte(ByteCmd3);
    send_byte(8'h07);
    send_byte(ByteEsc);
    send_byte(8'hFF);
    // The frame is complete; this byte is ignored but reloads the timer.
    send_byte(8'h12);
    repeat (3) send_item(OpTick, 8'hFF);
    send_item(OpRestart, 8'h00);
    send_byte(ByteEsc);
    send_byte(ByteHdr);
    send_byte(ByteHdr);
    send_byte(ByteCmd4);

    run_segment(16'd1, 25, 64, 35);
    run_segment(16'hFFFF, 64, 25, 35);
    run_segment(16'd0, 0, 0, 35);
    run_segment(16'd6, 0, 0, 35);

    settle();
    repeat (32) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("serial_frame_receiver_core: match");
    end else begin
      $display("serial_frame_receiver_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sfr_pkg.sv
rtl/core/sfr_in_if.sv
rtl/core/sfr_out_if.sv
rtl/core/sfr_ctrl.sv
rtl/core/sfr_dpath.sv
rtl/core/serial_frame_receiver_core.sv
bench/serial_frame_receiver_checker.sv
bench/serial_frame_receiver_core_test.sv
